>>> src/mmeu_pkg.sv
package mmeu_pkg;

  localparam int unsigned IdW        = 11;
  localparam int unsigned AngleW     = 16;
  localparam int unsigned SpeedW     = 16;
  localparam int unsigned CurrentW   = 16;
  localparam int unsigned CurScaledW = 19;
  localparam int unsigned HallW      = 8;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned TurnW      = 32;
  localparam int unsigned CountW     = 6;
  localparam int unsigned ActW       = 9;
  localparam int unsigned CfgIdxW    = 3;

  localparam int unsigned Bus0Motors = 7;
  localparam int unsigned Bus1Motors = 5;
  localparam int unsigned HalfTurn   = 4096;
  localparam int unsigned TurnShift  = 13;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BUS0_BASE  = 3'd0,
    REG_BUS1_SLOT7 = 3'd1,
    REG_BUS1_SLOT8 = 3'd2,
    REG_BUS1_SLOT9 = 3'd3,
    REG_BUS1_SLOT10 = 3'd4,
    REG_BUS1_SLOT11 = 3'd5
  } cfg_reg_t;

  // classified frame handed from front to back
  typedef struct packed {
    logic                  matched;
    logic [SlotW-1:0]      slot;
    logic [AngleW-1:0]     angle;
    logic [SpeedW-1:0]     speed;
    logic [CurScaledW-1:0] current;
    logic [HallW-1:0]      hall;
    logic                  pulse;
  } item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

>>> src/multi_motor_encoder_unwrap_top.sv
// an accepted item is written into the queue, then registered into the output registers when the back end loads it
// throughput: one item per cycle while out_ready is high, set by the slot update in the back end
// a two-entry queue separates classification from the slot update
// reset (synchronous, active high) clears slot state, counters and the queue
// and loads the identifier registers with their default values
module multi_motor_encoder_unwrap_top
  import mmeu_pkg::*;
#(
  parameter int unsigned MOTOR_SLOTS     = 12,
  parameter int unsigned CAL_FRAMES      = 51,
  parameter int unsigned ACTIVITY_PERIOD = 500
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [IdW-1:0]           cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     bus_select,
  input  logic [IdW-1:0]           frame_id,
  input  logic [AngleW-1:0]        angle_raw,
  input  logic signed [SpeedW-1:0] speed_raw,
  input  logic [CurrentW-1:0]      current_raw,
  input  logic [HallW-1:0]         hall_raw,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     matched,
  output logic [SlotW-1:0]         slot,
  output logic                     calibrating,
  output logic [AngleW-1:0]        angle_out,
  output logic signed [SpeedW-1:0] speed_out,
  output logic [CurScaledW-1:0]    current_scaled,
  output logic [HallW-1:0]         hall_out,
  output logic signed [TurnW-1:0]  turn_count,
  output logic signed [TurnW-1:0]  angle_total,
  output logic                     activity_pulse
);

  item_t   front_item;
  item_t   back_item;
  q_ctrl_t q_ctrl;
  q_stat_t q_stat;
  logic    take;
  logic    pop;

  assign in_ready    = !q_stat.full;
  assign take        = in_valid && in_ready;
  assign q_ctrl.push = take;
  assign q_ctrl.pop  = pop;

  mmeu_front #(
    .MOTOR_SLOTS     (MOTOR_SLOTS),
    .ACTIVITY_PERIOD (ACTIVITY_PERIOD)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .take        (take),
    .bus_select  (bus_select),
    .frame_id    (frame_id),
    .angle_raw   (angle_raw),
    .speed_raw   (speed_raw),
    .current_raw (current_raw),
    .hall_raw    (hall_raw),
    .item        (front_item)
  );

  mmeu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (q_ctrl),
    .wr_item (front_item),
    .rd_item (back_item),
    .stat    (q_stat)
  );

  mmeu_back #(
    .MOTOR_SLOTS (MOTOR_SLOTS),
    .CAL_FRAMES  (CAL_FRAMES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .q_item         (back_item),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .matched        (matched),
    .slot           (slot),
    .calibrating    (calibrating),
    .angle_out      (angle_out),
    .speed_out      (speed_out),
    .current_scaled (current_scaled),
    .hall_out       (hall_out),
    .turn_count     (turn_count),
    .angle_total    (angle_total),
    .activity_pulse (activity_pulse)
  );

endmodule

>>> src/mmeu_front.sv
module mmeu_front
  import mmeu_pkg::*;
#(
  parameter int unsigned MOTOR_SLOTS     = 12,
  parameter int unsigned ACTIVITY_PERIOD = 500
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [IdW-1:0]      cfg_data,
  input  logic                take,
  input  logic                bus_select,
  input  logic [IdW-1:0]      frame_id,
  input  logic [AngleW-1:0]   angle_raw,
  input  logic [SpeedW-1:0]   speed_raw,
  input  logic [CurrentW-1:0] current_raw,
  input  logic [HallW-1:0]    hall_raw,
  output item_t               item
);

  logic [IdW-1:0] base_id;
  logic [IdW-1:0] bus1_id [Bus1Motors];
  logic [ActW-1:0] act_count;
  logic [ActW-1:0] act_inc;
  logic            act_hit;
  logic [IdW:0]    id_diff;
  logic            map_hit;
  logic [SlotW-1:0] map_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id    <= IdW'(513);
      bus1_id[0] <= IdW'(517);
      bus1_id[1] <= IdW'(518);
      bus1_id[2] <= IdW'(513);
      bus1_id[3] <= IdW'(514);
      bus1_id[4] <= IdW'(515);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUS0_BASE:   base_id    <= cfg_data;
        REG_BUS1_SLOT7:  bus1_id[0] <= cfg_data;
        REG_BUS1_SLOT8:  bus1_id[1] <= cfg_data;
        REG_BUS1_SLOT9:  bus1_id[2] <= cfg_data;
        REG_BUS1_SLOT10: bus1_id[3] <= cfg_data;
        REG_BUS1_SLOT11: bus1_id[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // activity counter advances on every item, matched or not
  assign act_inc = act_count + ActW'(1);
  assign act_hit = (act_inc >= ActW'(ACTIVITY_PERIOD));

  always_ff @(posedge clk) begin
    if (rst) begin
      act_count <= '0;
    end else if (take) begin
      act_count <= act_hit ? '0 : act_inc;
    end
  end

  assign id_diff = {1'b0, frame_id} - {1'b0, base_id};

  always_comb begin
    map_hit  = 1'b0;
    map_slot = '0;
    if (!bus_select) begin
      if (!id_diff[IdW] && (id_diff[IdW-1:0] < IdW'(Bus0Motors))) begin
        map_hit  = 1'b1;
        map_slot = id_diff[SlotW-1:0];
      end
    end else begin
      // lowest slot wins on duplicate identifiers
      for (int k = Bus1Motors - 1; k >= 0; k--) begin
        if (bus1_id[k] == frame_id) begin
          map_hit  = 1'b1;
          map_slot = SlotW'(Bus0Motors + k);
        end
      end
    end
    if ({1'b0, map_slot} >= (SlotW + 1)'(MOTOR_SLOTS)) begin
      map_hit = 1'b0;
    end
  end

  always_comb begin
    item.matched = map_hit;
    item.slot    = map_hit ? map_slot : '0;
    item.angle   = angle_raw;
    item.speed   = speed_raw;
    item.current = {1'b0, current_raw, 2'b00} + {3'b000, current_raw};
    item.hall    = hall_raw;
    item.pulse   = act_hit;
  end

endmodule

>>> src/mmeu_queue.sv
module mmeu_queue
  import mmeu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  q_ctrl_t ctrl,
  input  item_t   wr_item,
  output item_t   rd_item,
  output q_stat_t stat
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (ctrl.push) wr_ptr <= ~wr_ptr;
      if (ctrl.pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, ctrl.push} - {1'b0, ctrl.pop};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) entry[wr_ptr] <= wr_item;
  end

  assign rd_item        = entry[rd_ptr];
  assign stat.full      = fill[1];
  assign stat.not_empty = (fill != 2'd0);

endmodule

>>> src/mmeu_back.sv
module mmeu_back
  import mmeu_pkg::*;
#(
  parameter int unsigned MOTOR_SLOTS = 12,
  parameter int unsigned CAL_FRAMES  = 51
) (
  input  logic                         clk,
  input  logic                         rst,
  input  q_stat_t                      q_stat,
  input  item_t                        q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         matched,
  output logic [SlotW-1:0]             slot,
  output logic                         calibrating,
  output logic [AngleW-1:0]            angle_out,
  output logic signed [SpeedW-1:0]     speed_out,
  output logic [CurScaledW-1:0]        current_scaled,
  output logic [HallW-1:0]             hall_out,
  output logic signed [TurnW-1:0]      turn_count,
  output logic signed [TurnW-1:0]      angle_total,
  output logic                         activity_pulse
);

  localparam int unsigned IdxW = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

  logic [CountW-1:0] frame_count [MOTOR_SLOTS];
  logic [AngleW-1:0] prev_angle  [MOTOR_SLOTS];
  logic [AngleW-1:0] zero_offset [MOTOR_SLOTS];
  logic [TurnW-1:0]  turns       [MOTOR_SLOTS];

  logic              load;
  logic [IdxW-1:0]   idx;
  logic              cal;
  logic [AngleW:0]   diff;
  logic [TurnW-1:0]  turns_next;
  logic [AngleW-1:0] offset_next;
  logic [CountW-1:0] count_next;
  logic [TurnW-1:0]  total;

  assign load  = q_stat.not_empty && (!out_valid || out_ready);
  assign q_pop = load;
  assign idx   = q_item.slot[IdxW-1:0];

  always_comb begin
    cal  = (frame_count[idx] < CountW'(CAL_FRAMES));
    diff = {1'b0, q_item.angle} - {1'b0, prev_angle[idx]};
    turns_next = turns[idx];
    // a jump of more than half a turn either way is a wrap of the encoder
    if (!cal) begin
      if (!diff[AngleW] && (diff[AngleW-1:0] > AngleW'(HalfTurn))) begin
        turns_next = turns[idx] - TurnW'(1);
      end else if (diff[AngleW] && (diff < (AngleW + 1)'(-HalfTurn))) begin
        turns_next = turns[idx] + TurnW'(1);
      end
    end
    offset_next = cal ? q_item.angle : zero_offset[idx];
    count_next  = (frame_count[idx] == '1) ? frame_count[idx]
                                           : frame_count[idx] + CountW'(1);
    total = {turns_next[TurnW-TurnShift-1:0], {TurnShift{1'b0}}}
          + TurnW'(q_item.angle) - TurnW'(offset_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_SLOTS; i++) begin
        frame_count[i] <= '0;
        prev_angle[i]  <= '0;
        zero_offset[i] <= '0;
        turns[i]       <= '0;
      end
    end else if (load && q_item.matched) begin
      frame_count[idx] <= count_next;
      prev_angle[idx]  <= q_item.angle;
      zero_offset[idx] <= offset_next;
      turns[idx]       <= turns_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      activity_pulse <= q_item.pulse;
      matched        <= q_item.matched;
      slot           <= q_item.slot;
      if (q_item.matched) begin
        calibrating    <= cal;
        angle_out      <= q_item.angle;
        speed_out      <= cal ? '0 : $signed(q_item.speed);
        current_scaled <= cal ? '0 : q_item.current;
        hall_out       <= cal ? '0 : q_item.hall;
        turn_count     <= $signed(turns_next);
        angle_total    <= $signed(total);
      end else begin
        calibrating    <= 1'b0;
        angle_out      <= '0;
        speed_out      <= '0;
        current_scaled <= '0;
        hall_out       <= '0;
        turn_count     <= '0;
        angle_total    <= '0;
      end
    end
  end

endmodule
